// ===== design/signed_int_to_decimal_text_assert.svh =====
// assertion macros for the signed integer to decimal text block
// depends on nothing; included by the top level
`ifndef SIGNED_INT_TO_DECIMAL_TEXT_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_TEXT_ASSERT_SVH
`ifndef SYNTH
// clocked property, checked outside reset
`define SIDT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// implication form built on the one above
`define SIDT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  `SIDT_ASSERT(lbl, clk, rstn, (ante) |-> (cons), msg)
`else
`define SIDT_ASSERT(lbl, clk, rstn, prop, msg)
`define SIDT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== design/sidt_pkg.sv =====
// shared types and constants for the signed integer to decimal text block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package sidt_pkg;

  localparam logic [5:0] CHAR_ZERO  = 6'h30;
  localparam logic [5:0] CHAR_MINUS = 6'h2d;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_SKIP,
    ST_EMIT
  } sidt_state_e;

  // controls for the shift-add-3 converter
  typedef struct packed {
    logic load;
    logic step;
    logic dshift;
  } sidt_ctl_t;

  // controls for the output register
  typedef struct packed {
    logic valid;
    logic minus;
    logic last;
  } sidt_emit_t;

endpackage
`default_nettype wire

// ===== design/sidt_dabble.sv =====
// bit-serial binary to bcd converter (shift-add-3) with a digit shift-out path
// depends on sidt_pkg
`timescale 1ns / 1ps
`default_nettype none
module sidt_dabble
  import sidt_pkg::*;
#(
  parameter int VALUE_BITS = 64,
  parameter int DIGITS     = 20
) (
  input  wire logic                  clk_i,
  input  wire sidt_ctl_t             ctl_i,
  input  wire logic [VALUE_BITS-1:0] mag_i,
  output logic [3:0]                 digit_o
);

  localparam int BcdW = 4 * DIGITS;

  logic [VALUE_BITS-1:0] mag_q, mag_d;
  logic [BcdW-1:0]       bcd_q, bcd_d;
  logic [BcdW-1:0]       adj;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int k = 0; k < DIGITS; k++) begin
      if (bcd_q[4*k +: 4] >= 4'd5) begin
        adj[4*k +: 4] = bcd_q[4*k +: 4] + 4'd3;
      end else begin
        adj[4*k +: 4] = bcd_q[4*k +: 4];
      end
    end
  end

  always_comb begin
    mag_d = mag_q;
    bcd_d = bcd_q;
    if (ctl_i.load) begin
      mag_d = mag_i;
      bcd_d = '0;
    end else if (ctl_i.step) begin
      mag_d = {mag_q[VALUE_BITS-2:0], 1'b0};
      bcd_d = {adj[BcdW-2:0], mag_q[VALUE_BITS-1]};
    end else if (ctl_i.dshift) begin
      bcd_d = {bcd_q[BcdW-5:0], 4'b0000};
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    bcd_q <= bcd_d;
  end

  assign digit_o = bcd_q[BcdW-1 -: 4];

endmodule
`default_nettype wire

// ===== design/sidt_fmt.sv =====
// output register: turns a bcd digit or the sign into an ascii character
// depends on sidt_pkg
`timescale 1ns / 1ps
`default_nettype none
module sidt_fmt
  import sidt_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire sidt_emit_t emit_i,
  input  wire logic [3:0] digit_i,
  output logic            char_valid_o,
  output logic [5:0]      character_o,
  output logic            is_last_o
);

  logic       valid_q;
  logic [5:0] char_q, char_d;
  logic       last_q;

  always_comb begin
    if (emit_i.minus) begin
      char_d = CHAR_MINUS;
    end else begin
      char_d = CHAR_ZERO + {2'b00, digit_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      valid_q <= emit_i.valid;
      last_q  <= emit_i.valid & emit_i.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_i.valid) begin
      char_q <= char_d;
    end
  end

  assign char_valid_o = valid_q;
  assign character_o  = char_q;
  assign is_last_o    = last_q;

endmodule
`default_nettype wire

// ===== design/signed_int_to_decimal_text.sv =====
// busy stays high from the accepting edge through a shift-add-3 pass, one
// value bit per cycle, the minus sign for a negative value, then a digit
// shift register skipping leading zeros and sending one character a cycle;
// no new value is accepted while busy
// the last character strobes in the first idle cycle; the receiver cannot stall
// reset clears the sequencer and the strobe; data registers are not reset
`timescale 1ns / 1ps
`default_nettype none
`include "signed_int_to_decimal_text_assert.svh"
module signed_int_to_decimal_text
  import sidt_pkg::*;
#(
  parameter int VALUE_BITS = 64
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [VALUE_BITS-1:0] value_i,
  output logic                              char_valid_o,
  output logic [5:0]                        character_o,
  output logic                              is_last_o
);

  // enough decimal digits for 2^(VALUE_BITS-1)
  localparam int DIGITS  = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int BitCntW = $clog2(VALUE_BITS + 1);
  localparam int DigCntW = $clog2(DIGITS + 1);

  sidt_state_e          state_q, state_d;
  logic [BitCntW-1:0]   bitcnt_q, bitcnt_d;
  logic [DigCntW-1:0]   digcnt_q, digcnt_d;
  logic                 neg_q, neg_d;
  logic                 accept;
  logic [VALUE_BITS-1:0] raw, mag;
  logic [3:0]           top_digit;
  sidt_ctl_t            ctl;
  sidt_emit_t           emit;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start & ~busy;

  // magnitude; the most negative value maps onto 2^(VALUE_BITS-1) unsigned
  assign raw = value_i;
  assign mag = raw[VALUE_BITS-1] ? (~raw + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : raw;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_CONV;
      end
      ST_CONV: begin
        if (bitcnt_q == BitCntW'(1)) state_d = neg_q ? ST_SIGN : ST_SKIP;
      end
      ST_SIGN: begin
        state_d = ST_SKIP;
      end
      ST_SKIP: begin
        // stop at the first nonzero digit, keep at least one
        if (top_digit != 4'd0 || digcnt_q == DigCntW'(1)) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (digcnt_q == DigCntW'(1)) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and counters
  always_comb begin
    ctl      = '0;
    emit     = '0;
    bitcnt_d = bitcnt_q;
    digcnt_d = digcnt_q;
    neg_d    = neg_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ctl.load = 1'b1;
          neg_d    = raw[VALUE_BITS-1];
          bitcnt_d = BitCntW'(VALUE_BITS);
        end
      end
      ST_CONV: begin
        ctl.step = 1'b1;
        bitcnt_d = bitcnt_q - BitCntW'(1);
        digcnt_d = DigCntW'(DIGITS);
      end
      ST_SIGN: begin
        emit.valid = 1'b1;
        emit.minus = 1'b1;
      end
      ST_SKIP: begin
        if (top_digit == 4'd0 && digcnt_q != DigCntW'(1)) begin
          ctl.dshift = 1'b1;
          digcnt_d   = digcnt_q - DigCntW'(1);
        end
      end
      ST_EMIT: begin
        emit.valid = 1'b1;
        emit.last  = (digcnt_q == DigCntW'(1));
        ctl.dshift = 1'b1;
        digcnt_d   = digcnt_q - DigCntW'(1);
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      bitcnt_q <= '0;
      digcnt_q <= '0;
      neg_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      bitcnt_q <= bitcnt_d;
      digcnt_q <= digcnt_d;
      neg_q    <= neg_d;
    end
  end

  sidt_dabble #(
    .VALUE_BITS (VALUE_BITS),
    .DIGITS     (DIGITS)
  ) u_dabble (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .mag_i   (mag),
    .digit_o (top_digit)
  );

  sidt_fmt u_fmt (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .emit_i       (emit),
    .digit_i      (top_digit),
    .char_valid_o (char_valid_o),
    .character_o  (character_o),
    .is_last_o    (is_last_o)
  );

  // an accepted item makes the block busy on the next cycle
  `SIDT_ASSERT_IMP(a_accept_busy, clk_i, rst_ni, accept, ##1 busy, "item accepted but not busy")
  // the last character closes the run and frees the block
  `SIDT_ASSERT_IMP(a_last_idle, clk_i, rst_ni, is_last_o, char_valid_o && !busy, "last char while busy")
  // characters come only from the sign or digit phases
  `SIDT_ASSERT_IMP(a_strobe_src, clk_i, rst_ni, char_valid_o, $past(emit.valid), "stray strobe")
  // the minus sign is never the last character
  `SIDT_ASSERT_IMP(a_minus_first, clk_i, rst_ni, char_valid_o && character_o == CHAR_MINUS, !is_last_o, "minus flagged last")

endmodule
`default_nettype wire
